[rtl/fmg_pkg.sv]
// ----------------------------------------------------------------------------
// fmg_pkg: shared types, constants and fixed-point helpers
// Fixed-point formats, register indexes, status codes and the rounding
// multiply used across the model evaluation pipeline.
// ----------------------------------------------------------------------------
package fmg_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int MAX_COEFS = 6;
    localparam int NUM_COEFS = 6;
    localparam int NUM_LANES = NUM_COEFS / 2;
    localparam int TRIPLE_TERMS = NUM_COEFS / 3;
    localparam int CFG_IDX_W = 3;
    localparam int COEF_IDX_W = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_TYPE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARAM_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_0      = 3'd2;

    typedef enum logic [1:0] {
        MODEL_CONST = 2'd0,
        MODEL_EXP   = 2'd1,
        MODEL_GAUSS = 2'd2,
        MODEL_SHIFT = 2'd3
    } model_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_ZERO_WIDTH = 2'd1,
        STATUS_SAT        = 2'd2
    } status_t;

    // divider: quotient bits resolved, bits per stage
    localparam int DIV_QBITS  = 36;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = DIV_QBITS / DIV_STEP;
    localparam int DIV_LAT    = DIV_STAGES + 2;

    // exponential unit latency and constants
    localparam int EXP_LAT = 10;
    localparam int HORNER_STEPS = 6;
    localparam logic signed [63:0] LOG2E_Q30 = 64'sd1549082005;
    localparam logic [31:0] Q30_ONE = 32'd1073741824;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;
    localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

    typedef struct packed {
        logic signed [31:0] val;
        logic               sat;
    } qres_t;

    typedef struct packed {
        logic signed [31:0] v;
        logic signed [31:0] e;
        logic signed [31:0] d1;
        logic signed [31:0] d2;
        logic               flag;
    } lane_out_t;

    // Taylor coefficients of 2^f in powers of f, Q30
    function automatic logic [31:0] taylor_coef(input int k);
        logic [31:0] c;
        unique case (k)
            0: c = 32'd1073741824;
            1: c = 32'd744261118;
            2: c = 32'd257941248;
            3: c = 32'd59597083;
            4: c = 32'd10327387;
            5: c = 32'd1431680;
            6: c = 32'd165394;
            7: c = 32'd16378;
            default: c = 32'd0;
        endcase
        return c;
    endfunction

    // clamp a wide signed value to 32 bits
    function automatic qres_t sat64(input logic signed [63:0] v);
        qres_t r;
        if (v > SAT_MAX) begin
            r.val = 32'sh7FFFFFFF;
            r.sat = 1'b1;
        end
        else if (v < SAT_MIN) begin
            r.val = 32'sh80000000;
            r.sat = 1'b1;
        end
        else begin
            r.val = v[31:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    // fixed-point multiply, round half up, saturate
    function automatic qres_t qmul(input logic signed [31:0] a,
                                   input logic signed [31:0] b);
        logic signed [63:0] aa;
        logic signed [63:0] bb;
        logic signed [63:0] p;
        aa = a;
        bb = b;
        p = aa * bb + ROUND_HALF;
        p = p >>> FRAC_BITS;
        return sat64(p);
    endfunction

endpackage

[rtl/fmg_div.sv]
// ----------------------------------------------------------------------------
// fmg_div: pipelined signed fixed-point divider
// Computes (num << FRAC_BITS) / den truncated toward zero and saturated,
// resolving DIV_STEP quotient bits per stage.
// ----------------------------------------------------------------------------
module fmg_div
    import fmg_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic signed [31:0] quo,
    output logic               sat
);

    localparam int NM_W = DATA_W + FRAC_BITS;

    logic [31:0]          rem_reg  [DIV_STAGES+1];
    logic [DIV_QBITS-1:0] bits_reg [DIV_STAGES+1];
    logic [31:0]          dm_reg   [DIV_STAGES+1];
    logic                 neg_reg  [DIV_STAGES+1];
    logic                 big_reg  [DIV_STAGES+1];
    logic [31:0]          rem_next [DIV_STAGES+1];
    logic [DIV_QBITS-1:0] bits_next[DIV_STAGES+1];
    logic signed [31:0]   quo_reg;
    logic                 sat_reg;
    logic signed [31:0]   quo_next;
    logic                 sat_next;

    // magnitudes and overflow check on the high dividend bits
    logic [31:0]   nmag;
    logic [31:0]   dmag;
    logic [NM_W-1:0] nm;
    always_comb
    begin
        nmag = num[31] ? 32'(-num) : 32'(num);
        dmag = den[31] ? 32'(-den) : 32'(den);
        nm   = {nmag, {FRAC_BITS{1'b0}}};
    end

    // restoring steps, DIV_STEP per stage
    always_comb
    begin
        logic [31:0]          r;
        logic [DIV_QBITS-1:0] b;
        logic [32:0]          r2;
        rem_next[0]  = 32'(nm[NM_W-1:DIV_QBITS]);
        bits_next[0] = nm[DIV_QBITS-1:0];
        for (int i = 1; i <= DIV_STAGES; i++)
        begin
            r = rem_reg[i-1];
            b = bits_reg[i-1];
            for (int j = 0; j < DIV_STEP; j++)
            begin
                r2 = {r, b[DIV_QBITS-1]};
                b  = b << 1;
                if (r2 >= {1'b0, dm_reg[i-1]})
                begin
                    r2   = r2 - {1'b0, dm_reg[i-1]};
                    b[0] = 1'b1;
                end
                r = r2[31:0];
            end
            rem_next[i]  = r;
            bits_next[i] = b;
        end
    end

    // sign and saturation
    always_comb
    begin
        logic [DIV_QBITS-1:0] mag;
        mag = bits_reg[DIV_STAGES];
        quo_next = 32'(mag);
        sat_next = 1'b0;
        if (neg_reg[DIV_STAGES])
        begin
            if (big_reg[DIV_STAGES] || mag > DIV_QBITS'(64'h80000000))
            begin
                quo_next = 32'sh80000000;
                sat_next = 1'b1;
            end
            else
                quo_next = -quo_next;
        end
        else if (big_reg[DIV_STAGES] || mag > DIV_QBITS'(64'h7FFFFFFF))
        begin
            quo_next = 32'sh7FFFFFFF;
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem_next[0];
            bits_reg[0] <= bits_next[0];
            dm_reg[0]   <= dmag;
            neg_reg[0]  <= num[31] ^ den[31];
            big_reg[0]  <= 32'(nm[NM_W-1:DIV_QBITS]) >= dmag;
            for (int i = 1; i <= DIV_STAGES; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                bits_reg[i] <= bits_next[i];
                dm_reg[i]   <= dm_reg[i-1];
                neg_reg[i]  <= neg_reg[i-1];
                big_reg[i]  <= big_reg[i-1];
            end
            quo_reg <= quo_next;
            sat_reg <= sat_next;
        end
    end

    assign quo = quo_reg;
    assign sat = sat_reg;

endmodule

[rtl/fmg_exp.sv]
// ----------------------------------------------------------------------------
// fmg_exp: pipelined exp(-t) in signed fixed point
// exp(-t) = 2^u, u = -t*log2(e); 2^frac by a Horner series, one multiply
// per stage, then a rounding scale by 2^int.
// ----------------------------------------------------------------------------
module fmg_exp
    import fmg_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] t,
    output logic signed [31:0] e,
    output logic               sat
);

    localparam logic signed [63:0] HALF_Q30 = 64'sd1 <<< 29;
    localparam logic signed [63:0] S_BASE   = 64'(30 - FRAC_BITS);

    logic signed [63:0] prod_reg;
    logic signed [35:0] s_reg   [HORNER_STEPS+2];
    logic [29:0]        f30_reg [HORNER_STEPS+1];
    logic [31:0]        p_reg   [HORNER_STEPS+1];
    logic [31:0]        m_reg;
    logic signed [31:0] e_reg;
    logic               sat_reg;

    logic signed [63:0] u;
    logic signed [63:0] s_full;
    logic [29:0]        f30_next;
    logic [31:0]        p_next  [HORNER_STEPS+1];
    logic [63:0]        mprod;
    logic signed [31:0] e_next;
    logic               sat_next;

    // exponent split into integer and fraction
    always_comb
    begin
        u        = (-prod_reg + HALF_Q30) >>> 30;
        s_full   = S_BASE - (u >>> FRAC_BITS);
        f30_next = 30'(u[FRAC_BITS-1:0]) << (30 - FRAC_BITS);
    end

    // Horner steps
    always_comb
    begin
        logic [63:0] hp;
        p_next[0] = taylor_coef(7);
        for (int k = 1; k <= HORNER_STEPS; k++)
        begin
            hp = 64'(p_reg[k-1]) * 64'(f30_reg[k-1]);
            p_next[k] = taylor_coef(7 - k) + 32'(hp >> 30);
        end
        mprod = 64'(p_reg[HORNER_STEPS]) * 64'(f30_reg[HORNER_STEPS]);
    end

    // scale by the integer part with rounding
    always_comb
    begin
        logic signed [35:0] s;
        logic [4:0]         sh;
        logic [32:0]        r;
        s  = s_reg[HORNER_STEPS+1];
        sh = s[4:0];
        r  = 33'd0;
        e_next   = 32'sd0;
        sat_next = 1'b0;
        if (s >= 36'sd32)
            e_next = 32'sd0;
        else if (s >= 36'sd1)
        begin
            r = ({1'b0, m_reg} + (33'd1 << (sh - 5'd1))) >> sh;
            e_next = r[31:0];
        end
        else if (s < -36'sd1)
        begin
            e_next   = 32'sh7FFFFFFF;
            sat_next = 1'b1;
        end
        else
        begin
            r = (s == 36'sd0) ? {1'b0, m_reg} : {m_reg, 1'b0};
            if (r > 33'h07FFFFFFF)
            begin
                e_next   = 32'sh7FFFFFFF;
                sat_next = 1'b1;
            end
            else
                e_next = r[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= 64'(t) * LOG2E_Q30;
            s_reg[0]   <= 36'(s_full);
            f30_reg[0] <= f30_next;
            p_reg[0]   <= p_next[0];
            for (int k = 1; k <= HORNER_STEPS; k++)
            begin
                s_reg[k]   <= s_reg[k-1];
                f30_reg[k] <= f30_reg[k-1];
                p_reg[k]   <= p_next[k];
            end
            s_reg[HORNER_STEPS+1] <= s_reg[HORNER_STEPS];
            m_reg   <= Q30_ONE + 32'(mprod >> 30);
            e_reg   <= e_next;
            sat_reg <= sat_next;
        end
    end

    assign e   = e_reg;
    assign sat = sat_reg;

endmodule

[rtl/fmg_lane.sv]
// ----------------------------------------------------------------------------
// fmg_lane: one model term with its derivatives
// Evaluates one exponential, centred or shifted Gaussian term: argument
// division, exponential, products and the two derivative divisions.
// ----------------------------------------------------------------------------
module fmg_lane
    import fmg_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  model_t             model,
    input  logic signed [31:0] x,
    input  logic signed [31:0] a,
    input  logic signed [31:0] c,
    input  logic signed [31:0] w,
    output lane_out_t          res
);

    typedef struct packed {
        logic signed [31:0] t1;
        logic signed [31:0] nxa;
        logic               flag;
    } seg1_t;

    typedef struct packed {
        logic signed [31:0] arg;
        logic signed [31:0] nxa;
        logic               flag;
    } seg2_t;

    typedef struct packed {
        logic signed [31:0] v;
        logic signed [31:0] d1m;
        logic signed [31:0] e;
        logic               flag;
    } seg3_t;

    logic m1;
    logic m3;
    logic m23;
    assign m1  = (model == MODEL_EXP);
    assign m3  = (model == MODEL_SHIFT);
    assign m23 = (model == MODEL_GAUSS) || (model == MODEL_SHIFT);

    seg1_t seg1_reg [DIV_LAT+1];
    seg2_t seg2_reg [EXP_LAT+1];
    seg3_t seg3_reg [DIV_LAT+1];
    logic signed [31:0] num_reg;
    logic signed [31:0] t_reg;
    logic signed [31:0] arg_div;
    logic               arg_sat;
    logic signed [31:0] e_exp;
    logic               e_sat;

    // first stage: shifted abscissa, exponent argument, -x*a
    seg1_t              seg1_next;
    logic signed [31:0] num_next;
    always_comb
    begin
        qres_t sub;
        qres_t negx;
        qres_t t1;
        qres_t nxa;
        sub  = sat64(64'(x) - 64'(c));
        negx = sat64(-64'(x));
        t1   = qmul(w, x);
        nxa  = qmul(negx.val, a);
        num_next       = m3 ? sub.val : x;
        seg1_next.t1   = t1.val;
        seg1_next.nxa  = nxa.val;
        seg1_next.flag = (m3 & sub.sat) | (m1 & (t1.sat | negx.sat | nxa.sat));
    end

    fmg_div u_div_arg (
        .clk (clk),
        .en  (en),
        .num (num_reg),
        .den (w),
        .quo (arg_div),
        .sat (arg_sat)
    );

    // squared argument
    seg2_t              seg2_next;
    logic signed [31:0] t_next;
    always_comb
    begin
        qres_t sq;
        sq = qmul(arg_div, arg_div);
        t_next         = m1 ? seg1_reg[DIV_LAT].t1 : sq.val;
        seg2_next.arg  = arg_div;
        seg2_next.nxa  = seg1_reg[DIV_LAT].nxa;
        seg2_next.flag = seg1_reg[DIV_LAT].flag | (m23 & (arg_sat | sq.sat));
    end

    fmg_exp u_exp (
        .clk (clk),
        .en  (en),
        .t   (t_reg),
        .e   (e_exp),
        .sat (e_sat)
    );

    // product stages after the exponential
    logic signed [31:0] v1_reg, d1m1_reg, arg1_reg, e1_reg;
    logic               f1_reg;
    logic signed [31:0] g2_reg, v2_reg, d1m2_reg, arg2_reg, e2_reg;
    logic               f2_reg;
    logic signed [31:0] num_a_reg, num_b_reg;

    qres_t v_q, d1m_q, dbl_q, g_q, q_q;
    always_comb
    begin
        v_q   = qmul(a, e_exp);
        d1m_q = qmul(seg2_reg[EXP_LAT].nxa, e_exp);
        dbl_q = sat64(64'(v1_reg) * 64'sd2);
        g_q   = qmul(dbl_q.val, arg1_reg);
        q_q   = qmul(g2_reg, arg2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg     <= num_next;
            seg1_reg[0] <= seg1_next;
            for (int i = 1; i <= DIV_LAT; i++)
                seg1_reg[i] <= seg1_reg[i-1];

            t_reg       <= t_next;
            seg2_reg[0] <= seg2_next;
            for (int i = 1; i <= EXP_LAT; i++)
                seg2_reg[i] <= seg2_reg[i-1];

            v1_reg   <= v_q.val;
            d1m1_reg <= d1m_q.val;
            arg1_reg <= seg2_reg[EXP_LAT].arg;
            e1_reg   <= e_exp;
            f1_reg   <= seg2_reg[EXP_LAT].flag | e_sat | v_q.sat | (m1 & d1m_q.sat);

            g2_reg   <= g_q.val;
            v2_reg   <= v1_reg;
            d1m2_reg <= d1m1_reg;
            arg2_reg <= arg1_reg;
            e2_reg   <= e1_reg;
            f2_reg   <= f1_reg | (m23 & (dbl_q.sat | g_q.sat));

            num_a_reg        <= m3 ? g2_reg : q_q.val;
            num_b_reg        <= q_q.val;
            seg3_reg[0].v    <= v2_reg;
            seg3_reg[0].d1m  <= d1m2_reg;
            seg3_reg[0].e    <= e2_reg;
            seg3_reg[0].flag <= f2_reg | (m23 & q_q.sat);
            for (int i = 1; i <= DIV_LAT; i++)
                seg3_reg[i] <= seg3_reg[i-1];
        end
    end

    // derivative divisions by the width
    logic signed [31:0] quo_a, quo_b;
    logic               sat_a, sat_b;

    fmg_div u_div_d1 (
        .clk (clk),
        .en  (en),
        .num (num_a_reg),
        .den (w),
        .quo (quo_a),
        .sat (sat_a)
    );

    fmg_div u_div_d2 (
        .clk (clk),
        .en  (en),
        .num (num_b_reg),
        .den (w),
        .quo (quo_b),
        .sat (sat_b)
    );

    always_comb
    begin
        res.v    = seg3_reg[DIV_LAT].v;
        res.e    = seg3_reg[DIV_LAT].e;
        res.d1   = m1 ? seg3_reg[DIV_LAT].d1m : quo_a;
        res.d2   = quo_b;
        res.flag = seg3_reg[DIV_LAT].flag | (m23 & sat_a) | (m3 & sat_b);
    end

endmodule

[rtl/fit_model_with_gradient_top.sv]
// ----------------------------------------------------------------------------
// fit_model_with_gradient_top: fit model value and coefficient gradient
// Evaluates a constant, exponential-sum or Gaussian-sum model at one abscissa
// per cycle unless stalled, with the partial derivative for each coefficient.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: abscissa with in_valid/in_stall. A word is taken at a
//   clock edge with in_valid high and in_stall low.
//   Output channel: model_value, deriv_0..deriv_5 and status with
//   out_valid/out_stall; one result word for every input word, in order.
//   Configuration: cfg_we/cfg_index/cfg_data write model_type (0),
//   param_count (1) and coef_0..coef_5 (2..7); write only while idle.
//   Pipeline: the abscissa register loads at the accepting edge; after it
//   come two 11-stage dividers (4 quotient bits a stage), a 10-stage
//   exponential with one Horner multiply per stage, and 6 product, merge
//   and output stages, the last of which drives out_valid.
//   Throughput: one word per cycle while the pipeline is not stalled.
//   Stall: the whole pipeline holds while a result waits under out_stall;
//   in_stall is high exactly then. Nothing is lost or repeated.
//   Reset: rst_n clears all valid bits and loads the register defaults
//   (constant model, param_count 1, coefficients 0).
// ----------------------------------------------------------------------------
module fit_model_with_gradient_top
    import fmg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [31:0]   abscissa,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [31:0]   model_value,
    output logic signed [31:0]   deriv_0,
    output logic signed [31:0]   deriv_1,
    output logic signed [31:0]   deriv_2,
    output logic signed [31:0]   deriv_3,
    output logic signed [31:0]   deriv_4,
    output logic signed [31:0]   deriv_5,
    output logic [1:0]           status,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int LANE_LAT = 2 * DIV_LAT + EXP_LAT + 5;

    // configuration registers
    model_t             model_type_reg;
    logic [2:0]         param_count_reg;
    logic signed [31:0] coef_reg [NUM_COEFS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_type_reg  <= MODEL_CONST;
            param_count_reg <= 3'd1;
            for (int i = 0; i < NUM_COEFS; i++)
                coef_reg[i] <= 32'sd0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MODEL_TYPE)
                model_type_reg <= model_t'(cfg_data[1:0]);
            else if (cfg_index == REG_PARAM_COUNT)
                param_count_reg <= cfg_data[2:0];
            else
                coef_reg[COEF_IDX_W'(cfg_index - REG_COEF_0)] <= cfg_data;
        end
    end

    // pipeline advance
    logic out_valid_reg;
    logic en;
    logic vld_reg [LANE_LAT+1];
    logic signed [31:0] x_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LANE_LAT; i++)
                vld_reg[i] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= LANE_LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
            out_valid_reg <= vld_reg[LANE_LAT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            x_reg <= abscissa;
    end

    // term lanes with their coefficient selection
    logic      m3;
    logic      m23;
    lane_out_t lane_res [NUM_LANES];
    logic signed [31:0] lane_w [NUM_LANES];

    assign m3  = (model_type_reg == MODEL_SHIFT);
    assign m23 = (model_type_reg == MODEL_GAUSS) || (model_type_reg == MODEL_SHIFT);

    for (genvar k = 0; k < NUM_LANES; k++)
    begin : g_lane
        localparam int IA3 = (3 * k     < NUM_COEFS) ? 3 * k     : 0;
        localparam int IC3 = (3 * k + 1 < NUM_COEFS) ? 3 * k + 1 : 0;
        localparam int IW3 = (3 * k + 2 < NUM_COEFS) ? 3 * k + 2 : 0;
        logic signed [31:0] a_sel;
        assign a_sel     = m3 ? coef_reg[IA3] : coef_reg[2*k];
        assign lane_w[k] = m3 ? coef_reg[IW3] : coef_reg[2*k+1];

        fmg_lane u_lane (
            .clk   (clk),
            .en    (en),
            .model (model_type_reg),
            .x     (x_reg),
            .a     (a_sel),
            .c     (coef_reg[IC3]),
            .w     (lane_w[k]),
            .res   (lane_res[k])
        );
    end

    // merge terms, map derivatives, status
    logic signed [31:0] value_next;
    logic signed [31:0] d_next [NUM_COEFS];
    status_t            status_next;
    always_comb
    begin
        logic [3:0]         nuse;
        logic               used;
        logic               ok;
        logic               zw_any;
        logic               sat_any;
        logic signed [33:0] acc;
        qres_t              accq;
        nuse    = (param_count_reg > 3'(MAX_COEFS)) ? 4'(MAX_COEFS) : {1'b0, param_count_reg};
        zw_any  = 1'b0;
        sat_any = 1'b0;
        acc     = 34'sd0;
        for (int i = 0; i < NUM_COEFS; i++)
            d_next[i] = 32'sd0;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            used = m3 ? (4'(3 * k + 3) <= nuse) : (4'(2 * k + 2) <= nuse);
            ok   = used && !(m23 && lane_w[k] == 32'sd0);
            if (used && m23 && lane_w[k] == 32'sd0)
                zw_any = 1'b1;
            if (ok)
            begin
                acc     = acc + {{2{lane_res[k].v[31]}}, lane_res[k].v};
                sat_any = sat_any | lane_res[k].flag;
                if (!m3)
                begin
                    d_next[2*k]   = lane_res[k].e;
                    d_next[2*k+1] = lane_res[k].d1;
                end
            end
        end
        for (int k = 0; k < TRIPLE_TERMS; k++)
        begin
            used = 4'(3 * k + 3) <= nuse;
            if (m3 && used && lane_w[k] != 32'sd0)
            begin
                d_next[3*k]   = lane_res[k].e;
                d_next[3*k+1] = lane_res[k].d1;
                d_next[3*k+2] = lane_res[k].d2;
            end
        end
        accq = sat64(64'(acc));
        value_next = accq.val;
        sat_any = sat_any | accq.sat;
        if (model_type_reg == MODEL_CONST)
        begin
            value_next = coef_reg[0];
            for (int i = 0; i < NUM_COEFS; i++)
                d_next[i] = 32'sd0;
            d_next[0] = ONE_Q;
            zw_any    = 1'b0;
            sat_any   = 1'b0;
        end
        priority if (zw_any)
            status_next = STATUS_ZERO_WIDTH;
        else if (sat_any)
            status_next = STATUS_SAT;
        else
            status_next = STATUS_OK;
    end

    // output word register
    logic signed [31:0] value_reg;
    logic signed [31:0] d_reg [NUM_COEFS];
    status_t            status_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
            for (int i = 0; i < NUM_COEFS; i++)
                d_reg[i] <= d_next[i];
        end
    end

    assign out_valid   = out_valid_reg;
    assign model_value = value_reg;
    assign deriv_0     = d_reg[0];
    assign deriv_1     = d_reg[1];
    assign deriv_2     = d_reg[2];
    assign deriv_3     = d_reg[3];
    assign deriv_4     = d_reg[4];
    assign deriv_5     = d_reg[5];
    assign status      = status_reg;

endmodule

[rtl/fmg_checker.sv]
// ----------------------------------------------------------------------------
// fmg_checker: port-level checks for the fit model block
// Watches the handshake and stall behaviour seen on the top-level ports.
// ----------------------------------------------------------------------------
module fmg_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic signed [31:0]   model_value,
    input logic signed [31:0]   deriv_0,
    input logic signed [31:0]   deriv_1,
    input logic signed [31:0]   deriv_2,
    input logic signed [31:0]   deriv_3,
    input logic signed [31:0]   deriv_4,
    input logic signed [31:0]   deriv_5,
    input logic [1:0]           status
);

    // input side holds only while a result word waits
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("in_stall does not follow the held output word");

    // output valid stays up while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped under stall");

    // stalled word keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(model_value) && $stable(deriv_0)
                                   && $stable(deriv_1) && $stable(deriv_2)
                                   && $stable(deriv_3) && $stable(deriv_4)
                                   && $stable(deriv_5) && $stable(status))
        else $error("output word changed under stall");

    // pipeline empty straight after reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output valid after reset");

endmodule

bind fit_model_with_gradient_top fmg_checker u_fmg_checker (.*);

[bench/fit_model_with_gradient_top_test.sv]
// ----------------------------------------------------------------------------
// fit_model_with_gradient_top_test: self-checking bench for the fit model
// Drives abscissa words through the block under a series of model settings.
// A local fixed-point predictor computes the model value, derivatives and
// status for each accepted word. Every result word is checked field by field.
// ----------------------------------------------------------------------------
module fit_model_with_gradient_top_test;
    import fmg_pkg::*;

    localparam int LATENCY   = 38;
    localparam int WATCHDOG  = 20000;
    localparam int PIPE_WAIT = LATENCY + 20;

    typedef struct {
        logic signed [31:0] value;
        logic signed [31:0] deriv [6];
        status_t            stat;
    } model_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [31:0] abscissa;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] model_value;
    logic signed [31:0] deriv_0, deriv_1, deriv_2, deriv_3, deriv_4, deriv_5;
    logic [1:0] status;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    fit_model_with_gradient_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .abscissa(abscissa),
        .out_valid(out_valid), .out_stall(out_stall),
        .model_value(model_value),
        .deriv_0(deriv_0), .deriv_1(deriv_1), .deriv_2(deriv_2),
        .deriv_3(deriv_3), .deriv_4(deriv_4), .deriv_5(deriv_5),
        .status(status),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor copy of the registers
    model_t            cur_model;
    logic [2:0]        cur_count;
    logic signed [31:0] cur_coef [6];
    bit                sat_hit;

    logic signed [31:0] pending_x [$];
    model_result_t      expected_results [$];

    int  failures;
    int  idle_cycles;
    bit  no_idle;
    bit  hold_output;
    int  hold_left;
    bit  hold_request;
    bit  in_stall_seen;
    bit  in_taken;

    // Taylor coefficients of 2^f, Q30
    localparam longint unsigned TAYLOR [8] = '{
        64'd1073741824, 64'd744261118, 64'd257941248, 64'd59597083,
        64'd10327387, 64'd1431680, 64'd165394, 64'd16378
    };

    // ------------------------------------------------------------------------
    // fixed-point arithmetic for the predictor
    // ------------------------------------------------------------------------
    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            sat_hit = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat_hit = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        longint p;
        p = a * b + (64'sd1 <<< (FRAC_BITS - 1));
        return clamp32(p >>> FRAC_BITS);
    endfunction

    function automatic longint fx_div(input longint n, input longint d);
        longint num;
        num = n * (64'sd1 <<< FRAC_BITS);
        return clamp32(num / d);
    endfunction

    function automatic longint exp_neg(input longint t);
        longint u, n, s;
        longint unsigned fr, f30, p, m;
        u = (-(t * 64'sd1549082005) + (64'sd1 <<< 29)) >>> 30;
        n = u >>> FRAC_BITS;
        fr = u & ((64'd1 << FRAC_BITS) - 1);
        f30 = fr << (30 - FRAC_BITS);
        p = TAYLOR[7];
        for (int k = 6; k >= 1; k--)
            p = TAYLOR[k] + ((p * f30) >> 30);
        m = 64'd1073741824 + ((p * f30) >> 30);
        s = (30 - FRAC_BITS) - n;
        if (s >= 32)
            return 0;
        if (s >= 1)
            return clamp32(longint'((m + (64'd1 << (s - 1))) >> s));
        if (s < -1) begin
            sat_hit = 1;
            return 64'sd2147483647;
        end
        return clamp32(longint'(m << (-s)));
    endfunction

    // model value, gradient and status at one abscissa
    function automatic model_result_t evaluate_model(input logic signed [31:0] xin);
        model_result_t r;
        longint x, acc, a, w, e, arg, fac, ae;
        longint d [6];
        bit zero_w;
        int nuse, len;
        x = xin;
        acc = 0;
        zero_w = 0;
        sat_hit = 0;
        for (int k = 0; k < 6; k++) d[k] = 0;
        nuse = (cur_count > MAX_COEFS) ? MAX_COEFS : cur_count;
        len = (cur_model == MODEL_SHIFT) ? 3 : 2;
        if (cur_model == MODEL_CONST) begin
            acc = cur_coef[0];
            d[0] = 64'sd1 <<< FRAC_BITS;
        end
        else begin
            for (int i = 0; i + len <= nuse; i += len) begin
                a = cur_coef[i];
                if (cur_model == MODEL_EXP) begin
                    e = exp_neg(fx_mul(cur_coef[i+1], x));
                    acc += fx_mul(a, e);
                    d[i] = e;
                    d[i+1] = fx_mul(fx_mul(clamp32(-x), a), e);
                end
                else if (cur_model == MODEL_GAUSS) begin
                    w = cur_coef[i+1];
                    if (w == 0) begin
                        zero_w = 1;
                        continue;
                    end
                    arg = fx_div(x, w);
                    e = exp_neg(fx_mul(arg, arg));
                    ae = fx_mul(a, e);
                    acc += ae;
                    fac = fx_mul(fx_mul(clamp32(ae * 2), arg), arg);
                    d[i] = e;
                    d[i+1] = fx_div(fac, w);
                end
                else begin
                    w = cur_coef[i+2];
                    if (w == 0) begin
                        zero_w = 1;
                        continue;
                    end
                    arg = fx_div(clamp32(x - cur_coef[i+1]), w);
                    e = exp_neg(fx_mul(arg, arg));
                    ae = fx_mul(a, e);
                    acc += ae;
                    fac = fx_mul(clamp32(ae * 2), arg);
                    d[i] = e;
                    d[i+1] = fx_div(fac, w);
                    d[i+2] = fx_div(fx_mul(fac, arg), w);
                end
            end
        end
        acc = clamp32(acc);
        r.value = acc[31:0];
        for (int k = 0; k < 6; k++) r.deriv[k] = d[k][31:0];
        r.stat = zero_w ? STATUS_ZERO_WIDTH : (sat_hit ? STATUS_SAT : STATUS_OK);
        return r;
    endfunction

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------------
    // driver: one pending word at a time, random gaps
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        bit taken;
        if (rst_n) begin
            taken = in_valid && !in_stall_seen;
            if (taken) begin
                // word was taken at the last rising edge
                void'(pending_x.pop_front());
            end
            // a valid word stays offered until it is taken
            if (pending_x.size() > 0 && (no_idle || (in_valid && !taken)
                                          || $urandom_range(99) >= 29)) begin
                in_valid <= 1'b1;
                abscissa <= pending_x[0];
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        in_stall_seen <= in_stall;
        in_taken = rst_n && in_valid && !in_stall;
        if (in_taken)
            expected_results.push_back(evaluate_model(abscissa));
    end

    // ------------------------------------------------------------------------
    // receiver stall: random, with a long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_request && hold_left == 0 && !hold_output) begin
            hold_output <= 1'b1;
            hold_left <= 300;
        end
        else if (hold_output) begin
            if (hold_left <= 1)
                hold_output <= 1'b0;
            hold_left <= hold_left - 1;
        end
        if (hold_output || hold_request)
            out_stall <= 1'b1;
        else
            out_stall <= !no_idle && ($urandom_range(99) < 29);
    end

    // ------------------------------------------------------------------------
    // monitor: compare each result word with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        model_result_t exp_r;
        logic signed [31:0] got [6];
        if (rst_n && out_valid && !out_stall) begin
            got = '{deriv_0, deriv_1, deriv_2, deriv_3, deriv_4, deriv_5};
            if (expected_results.size() == 0) begin
                $display("%0t: result word with none expected, value %h", $time,
                         model_value);
                failures++;
            end
            else begin
                exp_r = expected_results.pop_front();
                if (model_value !== exp_r.value) begin
                    $display("%0t: model_value expected %h actual %h", $time,
                             exp_r.value, model_value);
                    failures++;
                end
                for (int k = 0; k < 6; k++)
                    if (got[k] !== exp_r.deriv[k]) begin
                        $display("%0t: deriv_%0d expected %h actual %h", $time, k,
                                 exp_r.deriv[k], got[k]);
                        failures++;
                    end
                if (status !== exp_r.stat) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.stat, status);
                    failures++;
                end
            end
        end
    end

    // watchdog on cycles without any acceptance
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("fit_model_with_gradient_top_test: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODEL_TYPE:  cur_model = model_t'(val[1:0]);
            REG_PARAM_COUNT: cur_count = val[2:0];
            default:         cur_coef[idx - REG_COEF_0] = val;
        endcase
    endtask

    task automatic drain_pipe();
        while (pending_x.size() > 0 || expected_results.size() > 0)
            @(negedge clk);
        repeat (PIPE_WAIT) @(negedge clk);
    endtask

    // coefficient with a bias toward sensible magnitudes
    function automatic logic [31:0] random_coef();
        case ($urandom_range(9))
            0: return $urandom();
            1: return 32'h0;
            2: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return $signed($urandom_range(8 << 16)) - (4 << 16);
        endcase
    endfunction

    function automatic logic [31:0] random_x();
        case ($urandom_range(7))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return $signed($urandom_range(16 << 16)) - (8 << 16);
        endcase
    endfunction

    task automatic configure(input model_t m, input logic [2:0] cnt);
        write_reg(REG_MODEL_TYPE, 32'(m));
        write_reg(REG_PARAM_COUNT, 32'(cnt));
        for (int k = 0; k < 6; k++)
            write_reg(CFG_IDX_W'(REG_COEF_0 + k), random_coef());
    endtask

    initial
    begin
        failures = 0;
        no_idle = 0;
        hold_output = 0;
        hold_left = 0;
        hold_request = 0;
        in_stall_seen = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        abscissa = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cur_model = MODEL_CONST;
        cur_count = 3'd1;
        for (int k = 0; k < 6; k++) cur_coef[k] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset defaults, then each model with edge coefficients
        pending_x.push_back(32'h0);
        pending_x.push_back(32'h7FFFFFFF);
        pending_x.push_back(32'h80000000);
        drain_pipe();
        write_reg(REG_COEF_0, 32'h80000000);
        pending_x.push_back(32'h00010000);
        drain_pipe();
        // exponential, one term and one partial term
        write_reg(REG_MODEL_TYPE, 32'(MODEL_EXP));
        write_reg(REG_PARAM_COUNT, 3);
        write_reg(REG_COEF_0, 32'h00020000);
        write_reg(REG_COEF_0 + 3'd1, 32'h00008000);
        write_reg(REG_COEF_0 + 3'd2, 32'h7FFFFFFF);
        write_reg(REG_COEF_0 + 3'd3, 32'h80000000);
        write_reg(REG_COEF_0 + 3'd4, 32'hFFFF0000);
        write_reg(REG_COEF_0 + 3'd5, 32'h00010000);
        foreach (TAYLOR[i]) pending_x.push_back(random_x());
        pending_x.push_back(32'h80000000);
        drain_pipe();
        // centred Gaussian with a zero width in the second term
        write_reg(REG_MODEL_TYPE, 32'(MODEL_GAUSS));
        write_reg(REG_PARAM_COUNT, 7);
        write_reg(REG_COEF_0 + 3'd3, 32'h0);
        pending_x.push_back(32'h00018000);
        pending_x.push_back(32'h7FFFFFFF);
        drain_pipe();
        // shifted Gaussian, zero param_count then full
        write_reg(REG_MODEL_TYPE, 32'(MODEL_SHIFT));
        write_reg(REG_PARAM_COUNT, 0);
        pending_x.push_back(32'h00030000);
        drain_pipe();
        write_reg(REG_PARAM_COUNT, 6);
        write_reg(REG_COEF_0 + 3'd5, 32'h00020000);
        pending_x.push_back(32'h00030000);
        pending_x.push_back(32'h80000000);
        drain_pipe();

        // random phases over settings
        for (int ph = 0; ph < 20; ph++) begin
            configure(model_t'($urandom_range(3)), 3'($urandom_range(7)));
            no_idle = (ph == 3);
            for (int i = 0; i < 100; i++)
                pending_x.push_back(random_x());
            if (ph == 6) begin
                // long receiver hold-off while the sender keeps offering
                hold_request = 1;
                wait (hold_output);
                hold_request = 0;
            end
            drain_pipe();
        end
        no_idle = 0;

        if (failures == 0)
            $display("fit_model_with_gradient_top_test: PASS");
        else
            $display("fit_model_with_gradient_top_test: FAIL");
        $finish;
    end

endmodule
